// ===== hw/rtl/crd_pkg.sv =====
// Shared types and constants for the checked record deframer.
package crd_pkg;

	localparam logic [31:0] JOURNAL_MAGIC   = 32'h4a4e4c31;
	localparam logic [31:0] RECORD_MAGIC    = 32'h52454331;
	localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
	localparam logic [31:0] PAYLOAD_BYTES   = 32'd71;
	localparam logic [15:0] VERSION_RESET   = 16'd1;
	localparam int          QUEUE_DEPTH_DEF = 4;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_HDR_SHORT    = 3'd1;
	localparam logic [2:0] ST_HDR_BAD      = 3'd2;
	localparam logic [2:0] ST_REC_SHORT    = 3'd3;
	localparam logic [2:0] ST_MAGIC_BAD    = 3'd4;
	localparam logic [2:0] ST_PAYLOAD_SHORT = 3'd5;
	localparam logic [2:0] ST_CHECKSUM_BAD = 3'd6;
	localparam logic [2:0] ST_LENGTH_BAD   = 3'd7;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       record_done;
		logic       stream_done;
		logic [2:0] status;
	} out_word_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_head_t;

	typedef struct packed {
		logic        we;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

// ===== hw/rtl/crd_queue.sv =====
// Front end: accepts input words, classifies them and queues them for the back end.
module crd_queue #(
	parameter int DEPTH = crd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  crd_pkg::in_word_t in_word,
	output crd_pkg::q_head_t  head,
	input  logic              pop
);
	import crd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               do_pop;
	entry_t             new_entry;

	assign in_stall = (count_q == CNT_W'(DEPTH));
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (count_q != '0);

	always_comb begin
		if (in_word.command) begin
			new_entry.kind = KIND_END;
			new_entry.data = 8'd0;
		end else begin
			new_entry.kind = KIND_BYTE;
			new_entry.data = in_word.data_byte;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

endmodule

// ===== hw/rtl/crd_back.sv =====
// Back end: header and record parsing, FNV-1a 64 hash, status and output register.
module crd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  crd_pkg::q_head_t   head,
	output logic               pop,
	input  crd_pkg::cfg_wr_t   cfg_wr,
	output logic               out_valid,
	input  logic               out_stall,
	output crd_pkg::out_word_t out_word
);
	import crd_pkg::*;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_RECHDR  = 5'b00010,
		PH_PAYLOAD = 5'b00100,
		PH_HALTED  = 5'b01000,
		PH_ENDED   = 5'b10000
	} phase_t;

	// h * 0x100000001b3 as shifts and adds
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [2:0]  err_q, err_d;
	logic [15:0] version_q;
	logic [47:0] shift_q, shift_d;
	logic [31:0] len_q, len_d;
	logic [63:0] csum_q, csum_d;
	logic [63:0] hash_q, hash_d, hash_step;
	logic [31:0] left_q, left_d;
	logic        advance;
	logic        has_res;
	out_word_t   res;
	out_word_t   out_q;
	logic        out_valid_q;
	logic [2:0]  rec_st;
	logic [7:0]  b;

	assign advance   = !out_valid_q || !out_stall;
	assign pop       = head.valid && advance;
	assign b         = head.entry.data;
	assign hash_step = fnv_step(hash_q, b);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		err_d   = err_q;
		shift_d = shift_q;
		len_d   = len_q;
		csum_d  = csum_q;
		hash_d  = hash_q;
		left_d  = left_q;
		res     = '0;
		has_res = 1'b0;
		rec_st  = ST_OK;
		if (head.entry.kind == KIND_END) begin
			unique case (phase_q)
				PH_HEADER:  rec_st = ST_HDR_SHORT;
				PH_RECHDR:  rec_st = (cnt_q < 4'd4) ? ST_OK : ST_REC_SHORT;
				PH_PAYLOAD: rec_st = ST_PAYLOAD_SHORT;
				PH_HALTED, PH_ENDED: rec_st = err_q;
				default:    rec_st = err_q;
			endcase
			err_d           = rec_st;
			phase_d         = PH_ENDED;
			has_res         = 1'b1;
			res.stream_done = 1'b1;
			res.status      = rec_st;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					shift_d = {b, shift_q[47:8]};
					cnt_d   = cnt_q + 4'd1;
					if (cnt_q == 4'd5) begin
						cnt_d = 4'd0;
						if (shift_d[31:0] != JOURNAL_MAGIC || shift_d[47:32] != version_q) begin
							phase_d         = PH_HALTED;
							err_d           = ST_HDR_BAD;
							has_res         = 1'b1;
							res.record_done = 1'b1;
							res.status      = ST_HDR_BAD;
						end else begin
							phase_d = PH_RECHDR;
						end
					end
				end
				PH_RECHDR: begin
					if (cnt_q[3]) begin
						csum_d = {b, csum_q[63:8]};
					end else if (cnt_q[2]) begin
						len_d = {b, len_q[31:8]};
					end else begin
						shift_d = {b, shift_q[47:8]};
					end
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						cnt_d = 4'd0;
						if (shift_q[47:16] != RECORD_MAGIC) begin
							phase_d         = PH_HALTED;
							err_d           = ST_MAGIC_BAD;
							has_res         = 1'b1;
							res.record_done = 1'b1;
							res.status      = ST_MAGIC_BAD;
						end else begin
							hash_d = FNV_BASIS;
							left_d = len_q;
							if (len_q == 32'd0) begin
								if (csum_d != FNV_BASIS) begin
									rec_st = ST_CHECKSUM_BAD;
								end else if (len_q != PAYLOAD_BYTES) begin
									rec_st = ST_LENGTH_BAD;
								end
								if (rec_st != ST_OK) begin
									phase_d = PH_HALTED;
									err_d   = rec_st;
								end
								has_res         = 1'b1;
								res.record_done = 1'b1;
								res.status      = rec_st;
							end else begin
								phase_d = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					hash_d         = hash_step;
					left_d         = left_q - 32'd1;
					has_res        = 1'b1;
					res.out_byte   = b;
					res.byte_valid = 1'b1;
					if (left_q == 32'd1) begin
						if (hash_step != csum_q) begin
							rec_st = ST_CHECKSUM_BAD;
						end else if (len_q != PAYLOAD_BYTES) begin
							rec_st = ST_LENGTH_BAD;
						end
						if (rec_st != ST_OK) begin
							phase_d = PH_HALTED;
							err_d   = rec_st;
						end else begin
							phase_d = PH_RECHDR;
							cnt_d   = 4'd0;
						end
						res.record_done = 1'b1;
						res.status      = rec_st;
					end
				end
				PH_HALTED, PH_ENDED: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			cnt_q       <= 4'd0;
			err_q       <= ST_OK;
			version_q   <= VERSION_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr.we) begin
				version_q <= cfg_wr.data;
			end
			if (pop) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				err_q   <= err_d;
			end
			if (advance) begin
				out_valid_q <= pop && has_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q <= shift_d;
			len_q   <= len_d;
			csum_q  <= csum_d;
			hash_q  <= hash_d;
			left_q  <= left_d;
		end
		if (advance) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// ===== hw/rtl/checked_record_deframer.sv =====
// Top level of the checked record deframer: input queue, parser back end, config port.
// A result passes from the queue memory through the back end's output register after its input word is accepted.
// Throughput: one word per cycle while the output is not stalled; the hash step and status compare in
//   the back end are combinational, so the back end retires one queued word per cycle unless out_stall holds a result.
// Reset (arst_n low, asynchronous): queue empty, header phase, no output pending,
//   protocol_version back to 1.
module checked_record_deframer #(
	parameter int QUEUE_DEPTH = crd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  crd_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output crd_pkg::out_word_t out_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import crd_pkg::*;

	q_head_t head;
	logic    pop;
	cfg_wr_t cfg_wr;

	assign cfg_ready   = 1'b1;
	assign cfg_wr.we   = cfg_valid && cfg_ready;
	assign cfg_wr.data = cfg_data;

	crd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word (in_word),
		.head    (head),
		.pop     (pop)
	);

	crd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.cfg_wr   (cfg_wr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.byte_valid |-> out_word.out_byte == 8'd0)
		else $error("out_byte set without byte_valid");

	a_status_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.record_done && !out_word.stream_done |-> out_word.status == ST_OK)
		else $error("status set without a done flag");

	a_stream_end_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.stream_done |-> !out_word.byte_valid && !out_word.record_done)
		else $error("stream_done mixed with record output");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

endmodule
